>>> rtl/voxel_column_run_checker_unit_defines.svh
// ---------------------------------------------------------------------------
// Voxel column run checker assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ---------------------------------------------------------------------------
`ifndef VOXEL_COLUMN_RUN_CHECKER_UNIT_DEFINES_SVH
`define VOXEL_COLUMN_RUN_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define VCRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/vcrc_pkg.sv
// ---------------------------------------------------------------------------
// Voxel column run checker package
// Phase codes, status codes, register indexes and the normal table sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package vcrc_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [2:0] status_type;

   // parse phases
   localparam phase_type PH_SKIP    = 3'd0;
   localparam phase_type PH_COUNT   = 3'd1;
   localparam phase_type PH_COLOUR  = 3'd2;
   localparam phase_type PH_NORMAL  = 3'd3;
   localparam phase_type PH_REVERSE = 3'd4;

   // column status
   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_TRUNC   = 3'd1;
   localparam status_type ST_NOPROG  = 3'd2;
   localparam status_type ST_EXCEED  = 3'd3;
   localparam status_type ST_NORMAL  = 3'd4;
   localparam status_type ST_REVERSE = 3'd5;
   localparam status_type ST_TRAIL   = 3'd6;

   // register indexes
   localparam logic REG_COLUMN_HEIGHT = 1'b0;
   localparam logic REG_NORMAL_MODE   = 1'b1;

   localparam logic [7:0] COLUMN_HEIGHT_RESET = 8'd1;
   localparam logic [2:0] NORMAL_MODE_RESET   = 3'd0;

   // normal table size per mode; modes above four use the largest table
   function automatic logic [7:0] normal_table_size(input logic [2:0] mode);
      logic [7:0] size;
      case (mode)
         3'd0:    size = 8'd0;
         3'd1:    size = 8'd16;
         3'd2:    size = 8'd36;
         3'd3:    size = 8'd64;
         default: size = 8'd244;
      endcase
      return size;
   endfunction

endpackage

`default_nettype wire

>>> rtl/voxel_column_run_checker_unit.sv
// ---------------------------------------------------------------------------
// Voxel column run checker
// Parses a column's run-length byte stream and reports one status per column.
// ---------------------------------------------------------------------------
// One byte of the column stream is taken per beat on the req_ channel, and a
// new byte can be taken in every clock cycle while req_stall is low: the run
// parser is a small phase machine whose next state is settled combinationally
// from the byte and the column state registers. The byte flagged by
// req_last_of_column produces a single status beat on the rsp_ channel in the
// next cycle; the status sits in an output register, and req_stall rises only
// when the output register is full and stalled. The
// first error in a column is latched and later bytes are ignored until the
// last byte, after which the column state returns to its reset values.
// Register writes on csr_ are always ready and apply from the next byte.
`default_nettype none

`include "voxel_column_run_checker_unit_defines.svh"

module voxel_column_run_checker_unit
   import vcrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // byte stream in
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_of_column,
   // column status out
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_status,
   // register writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   // configuration registers
   logic [7:0] column_height_ff;
   logic [2:0] normal_mode_ff;

   // column state
   phase_type  phase_ff,       phase_in;
   logic [7:0] height_done_ff, height_done_in;
   logic [7:0] run_skip_ff,    run_skip_in;
   logic [7:0] run_count_ff,   run_count_in;
   logic [7:0] voxels_left_ff, voxels_left_in;
   status_type error_ff,       error_in;
   logic       normal_bad_ff,  normal_bad_in;

   // output register
   logic       rsp_valid_ff,   rsp_valid_in;
   status_type rsp_status_ff,  rsp_status_in;

   logic       req_accept;
   logic       csr_accept;
   logic [7:0] room;
   logic [8:0] run_span;
   logic [7:0] voxels_dec;
   status_type step_status;
   status_type col_status;

   // the output register is the only thing that can hold the input back
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;

   // height still open in this column, and what the pending run would cover
   assign room       = (height_done_ff >= column_height_ff) ?
                       8'd0 : column_height_ff - height_done_ff;
   assign run_span   = {1'b0, run_skip_ff} + {1'b0, req_data_byte};
   assign voxels_dec = voxels_left_ff - 8'd1;

   // -------------------------------------------------------------------------
   // Next column state for the byte at the input
   // -------------------------------------------------------------------------
   always_comb begin
      phase_in       = phase_ff;
      height_done_in = height_done_ff;
      run_skip_in    = run_skip_ff;
      run_count_in   = run_count_ff;
      voxels_left_in = voxels_left_ff;
      error_in       = error_ff;
      normal_bad_in  = normal_bad_ff;
      step_status    = ST_OK;

      if (error_ff == ST_OK) begin
         case (phase_ff)
            PH_SKIP: begin
               if (height_done_ff >= column_height_ff) begin
                  // column already full: anything more is trailing
                  error_in    = ST_TRAIL;
                  step_status = ST_TRAIL;
               end else if (req_last_of_column) begin
                  step_status = ST_TRUNC;
               end else begin
                  run_skip_in = req_data_byte;
                  phase_in    = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (req_last_of_column) begin
                  // truncated header wins over the run checks
                  step_status = ST_TRUNC;
               end else begin
                  run_count_in = req_data_byte;
                  if (run_skip_ff == 8'd0 && req_data_byte == 8'd0) begin
                     error_in    = ST_NOPROG;
                     step_status = ST_NOPROG;
                  end else if (run_span > {1'b0, room}) begin
                     error_in    = ST_EXCEED;
                     step_status = ST_EXCEED;
                  end else begin
                     normal_bad_in  = 1'b0;
                     voxels_left_in = req_data_byte;
                     phase_in       = (req_data_byte == 8'd0) ? PH_REVERSE : PH_COLOUR;
                  end
               end
            end
            PH_COLOUR: begin
               if (req_last_of_column) begin
                  step_status = ST_EXCEED;
               end else if (normal_mode_ff != 3'd0) begin
                  phase_in = PH_NORMAL;
               end else begin
                  voxels_left_in = voxels_dec;
                  phase_in       = (voxels_dec == 8'd0) ? PH_REVERSE : PH_COLOUR;
               end
            end
            PH_NORMAL: begin
               if (req_last_of_column) begin
                  step_status = ST_EXCEED;
               end else begin
                  if (req_data_byte >= normal_table_size(normal_mode_ff)) begin
                     normal_bad_in = 1'b1;
                  end
                  voxels_left_in = voxels_dec;
                  phase_in       = (voxels_dec == 8'd0) ? PH_REVERSE : PH_COLOUR;
               end
            end
            default: begin
               // reverse count byte closes the run
               if (normal_bad_ff) begin
                  error_in    = ST_NORMAL;
                  step_status = ST_NORMAL;
               end else if (req_data_byte != run_count_ff) begin
                  error_in    = ST_REVERSE;
                  step_status = ST_REVERSE;
               end else begin
                  height_done_in = height_done_ff + run_skip_ff + run_count_ff;
                  phase_in       = PH_SKIP;
                  if (req_last_of_column) begin
                     step_status = (height_done_in >= column_height_ff) ? ST_OK : ST_TRUNC;
                  end
               end
            end
         endcase
      end

      // a latched error overrides whatever the byte implied
      col_status = (error_in != ST_OK) ? error_in : step_status;

      // last byte: back to the start of a fresh column
      if (req_last_of_column) begin
         phase_in       = PH_SKIP;
         height_done_in = 8'd0;
         run_skip_in    = 8'd0;
         run_count_in   = 8'd0;
         voxels_left_in = 8'd0;
         error_in       = ST_OK;
         normal_bad_in  = 1'b0;
      end
   end

   // output register: load on the last beat, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      if (req_accept && req_last_of_column) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = col_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_height_ff <= COLUMN_HEIGHT_RESET;
         normal_mode_ff   <= NORMAL_MODE_RESET;
      end else if (csr_accept) begin
         case (csr_index)
            REG_COLUMN_HEIGHT: column_height_ff <= csr_wdata;
            REG_NORMAL_MODE:   normal_mode_ff   <= csr_wdata[2:0];
            default:           column_height_ff <= column_height_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SKIP;
         height_done_ff <= 8'd0;
         run_skip_ff    <= 8'd0;
         run_count_ff   <= 8'd0;
         voxels_left_ff <= 8'd0;
         error_ff       <= ST_OK;
         normal_bad_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         height_done_ff <= height_done_in;
         run_skip_ff    <= run_skip_in;
         run_count_ff   <= run_count_in;
         voxels_left_ff <= voxels_left_in;
         error_ff       <= error_in;
         normal_bad_ff  <= normal_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `VCRC_ASSERT_NEXT(a_last_clears, clock, reset,
      req_accept && req_last_of_column,
      rsp_valid_ff && phase_ff == PH_SKIP && error_ff == ST_OK && height_done_ff == 8'd0,
      "last beat did not produce status and clear column state")
   `VCRC_ASSERT_NEXT(a_error_sticky, clock, reset,
      error_ff != ST_OK && !(req_accept && req_last_of_column),
      error_ff == $past(error_ff),
      "latched error changed before end of column")
   `VCRC_ASSERT_NOW(a_stall_only_full, clock, reset,
      req_stall,
      rsp_valid_ff,
      "input stalled with empty output register")
   `VCRC_ASSERT_NOW(a_voxels_pending, clock, reset,
      phase_ff == PH_COLOUR || phase_ff == PH_NORMAL,
      voxels_left_ff != 8'd0,
      "in run body with no voxels left")

endmodule

`default_nettype wire

>>> sim/tb_voxel_column_run_checker_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Voxel column run checker testbench
// Feeds run-length column streams (well-formed, broken and noise) under
// random sender bursts and receiver stalls, predicts each column status in
// a scoreboard and compares every status beat against it.
// ---------------------------------------------------------------------------
module tb_voxel_column_run_checker_unit
   import vcrc_pkg::*;
();

   localparam int unsigned RANDOM_BYTES  = 380;
   localparam int unsigned MIN_COLUMNS   = 16;
   localparam int unsigned SETTLE_CYCLES = 4;      // status is one register deep
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // -----------------------------------------------------------------------
   // Column status scoreboard: mirrors the parse state of the block and keeps
   // the statuses still owed on rsp_, oldest first.
   // -----------------------------------------------------------------------
   class column_status_board;
      logic [7:0]  height;
      logic [2:0]  mode;
      phase_type   phase;
      logic [7:0]  covered;
      logic [7:0]  skip;
      logic [7:0]  count;
      logic [7:0]  left;
      status_type  err;
      bit          normal_bad;
      status_type  status_due[$];
      int unsigned fails;
      int unsigned entries_by_mode[5] = '{0, 16, 36, 64, 244};

      function new();
         height = COLUMN_HEIGHT_RESET;
         mode   = NORMAL_MODE_RESET;
         fails  = 0;
         clear();
      endfunction

      function void clear();
         phase      = PH_SKIP;
         covered    = 8'd0;
         skip       = 8'd0;
         count      = 8'd0;
         left       = 8'd0;
         err        = ST_OK;
         normal_bad = 1'b0;
      endfunction

      function void write_reg(logic idx, logic [7:0] data);
         if (idx == REG_COLUMN_HEIGHT) begin
            height = data;
         end else begin
            mode = data[2:0];
         end
      endfunction

      // modes above four share the largest table
      function int unsigned table_entries(logic [2:0] m);
         return entries_by_mode[(m > 3'd4) ? 4 : m];
      endfunction

      function void voxel_done();
         left  = left - 8'd1;
         phase = (left == 8'd0) ? PH_REVERSE : PH_COLOUR;
      endfunction

      // one byte with no error latched; result only matters on the last byte
      function status_type parse(logic [7:0] b, bit is_last);
         int unsigned room;
         int unsigned span;
         room = (covered >= height) ? 0 : height - covered;
         case (phase)
            PH_SKIP: begin
               if (covered >= height) begin
                  err = ST_TRAIL;
                  return ST_TRAIL;
               end
               if (is_last) return ST_TRUNC;
               skip  = b;
               phase = PH_COUNT;
               return ST_OK;
            end
            PH_COUNT: begin
               if (is_last) return ST_TRUNC;
               count = b;
               span  = skip + count;
               if (skip == 8'd0 && count == 8'd0) begin
                  err = ST_NOPROG;
                  return ST_NOPROG;
               end
               if (span > room) begin
                  err = ST_EXCEED;
                  return ST_EXCEED;
               end
               normal_bad = 1'b0;
               left       = count;
               phase      = (count == 8'd0) ? PH_REVERSE : PH_COLOUR;
               return ST_OK;
            end
            PH_COLOUR: begin
               if (is_last) return ST_EXCEED;
               if (mode != 3'd0) phase = PH_NORMAL;
               else voxel_done();
               return ST_OK;
            end
            PH_NORMAL: begin
               if (is_last) return ST_EXCEED;
               if (b >= table_entries(mode)) normal_bad = 1'b1;
               voxel_done();
               return ST_OK;
            end
            default: begin
               if (normal_bad) begin
                  err = ST_NORMAL;
                  return ST_NORMAL;
               end
               if (b != count) begin
                  err = ST_REVERSE;
                  return ST_REVERSE;
               end
               covered = covered + skip + count;
               phase   = PH_SKIP;
               if (is_last) return (covered >= height) ? ST_OK : ST_TRUNC;
               return ST_OK;
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b, bit is_last);
         status_type st;
         st = ST_OK;
         if (err == ST_OK) st = parse(b, is_last);
         if (err != ST_OK) st = err;
         if (is_last) begin
            status_due.insert(status_due.size(), st);
            clear();
         end
      endfunction

      function void match_status(status_type got);
         status_type want;
         if (status_due.size() == 0) begin
            $error("rsp_status %0d arrived with no column waiting", got);
            fails++;
            return;
         end
         want = status_due.pop_front();
         if (got !== want) begin
            $error("rsp_status mismatch: expected %0d, actual %0d", want, got);
            fails++;
         end
      endfunction

      function int unsigned pending();
         return status_due.size();
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT and stimulus signals; the stimulus side is known from time zero
   // -----------------------------------------------------------------------
   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic [7:0] req_data_byte      = 8'd0;
   logic       req_last_of_column = 1'b0;
   logic       rsp_stall          = 1'b0;
   logic       csr_valid          = 1'b0;
   logic       csr_index          = 1'b0;
   logic [7:0] csr_wdata          = 8'd0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic       csr_ready;

   column_status_board board = new();

   // config as the stimulus side sees it, used to shape legal columns
   logic [7:0] cfg_height = COLUMN_HEIGHT_RESET;
   logic [2:0] cfg_mode   = NORMAL_MODE_RESET;

   logic [7:0]  col_bytes[$];      // column under construction
   int unsigned burst_left    = 0;
   int unsigned bytes_taken   = 0;
   int unsigned columns_seen  = 0;
   int unsigned cycle_count   = 0;
   int unsigned stall_left    = 0;
   int unsigned stall_hold    = 0;
   int unsigned stall_style   = 0;

   voxel_column_run_checker_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_of_column (req_last_of_column),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the NBAs of
   // that edge land, so the values seen are the ones the DUT clocked in.
   // Status check goes first so a beat is never matched against a column
   // that closes on the same edge.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.match_status(rsp_status);
            columns_seen++;
         end
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            board.take_byte(req_data_byte, req_last_of_column);
            bytes_taken++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_voxel_column_run_checker_unit failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Receiver: switches at random intervals between no stall, sparse random
   // stall and long stall bursts, so output backpressure reaches back to
   // req_stall in every parse phase.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_left  = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_hold != 0) begin
               stall_hold--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_hold = $urandom_range(1, 12);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   // -----------------------------------------------------------------------
   // Sender tasks. Every task is entered and left on a rising edge.
   // -----------------------------------------------------------------------
   task automatic idle_cycles(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // one beat; bursts of random length, usually with a gap between them
   task automatic send_byte(input logic [7:0] b, input bit is_last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_last_of_column <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // append one byte to the column under construction
   task automatic add_byte(input logic [7:0] b);
      col_bytes.insert(col_bytes.size(), b);
   endtask

   // close = 0 leaves the column open (no last flag on the final byte)
   task automatic send_column(input bit close = 1'b1);
      if (col_bytes.size() == 0) add_byte(8'($urandom_range(0, 255)));
      foreach (col_bytes[i]) begin
         send_byte(col_bytes[i], close && (i == col_bytes.size() - 1));
      end
   endtask

   // hold off the sender until every owed status has come out, then give the
   // output register time to settle
   task automatic drain_columns();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // caller makes sure the sender is idle
   task automatic write_reg(input logic idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_COLUMN_HEIGHT) cfg_height = data;
      else cfg_mode = data[2:0];
      @(posedge clock);
   endtask

   // normal byte: mostly legal, with the table edge and out-of-table values
   function automatic logic [7:0] pick_normal();
      int unsigned lim;
      int unsigned r;
      lim = board.table_entries(cfg_mode);
      r   = $urandom_range(0, 19);
      if (r == 0) return 8'(lim);
      if (r == 1) return 8'($urandom_range(lim, 255));
      if (r <= 3) return 8'(lim - 1);
      return 8'($urandom_range(0, lim - 1));
   endfunction

   // well-formed column for the current config: runs fill the height exactly
   task automatic build_column();
      int unsigned covered;
      int unsigned room;
      int unsigned skip;
      int unsigned count;
      int unsigned most;
      col_bytes.delete();
      covered = 0;
      while (covered < cfg_height) begin
         room = cfg_height - covered;
         case ($urandom_range(0, 3))
            0:       skip = 0;
            1:       skip = room;
            default: skip = $urandom_range(0, room);
         endcase
         most  = (room - skip < 4) ? room - skip : 4;
         count = $urandom_range(0, most);
         if (skip == 0 && count == 0) count = 1;
         add_byte(8'(skip));
         add_byte(8'(count));
         repeat (count) begin
            add_byte(8'($urandom_range(0, 255)));
            if (cfg_mode != 3'd0) add_byte(pick_normal());
         end
         add_byte(8'(count));
         covered += skip + count;
      end
   endtask

   // damage a built column: cut it, hit one byte, add a tail, replace it by
   // noise, or lead with a run that covers nothing
   task automatic break_column();
      int unsigned n;
      n = col_bytes.size();
      case ($urandom_range(0, 4))
         0: if (n > 1) col_bytes = col_bytes[0:$urandom_range(0, n - 2)];
         1: if (n > 0) col_bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
         2: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
         3: begin
            col_bytes.delete();
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            col_bytes.push_front(8'd0);
            col_bytes.push_front(8'd0);
         end
      endcase
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      int unsigned byte_base;
      int unsigned column_base;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset config, height 1, no normals ---
      col_bytes = '{8'd0, 8'd1, 8'hA5, 8'd1};      // single voxel, fills column
      send_column();
      col_bytes = '{8'd0};                         // header cut at the skip byte
      send_column();
      col_bytes = '{8'd0, 8'd1};                   // header cut at the count byte
      send_column();
      col_bytes = '{8'd0, 8'd0, 8'd3, 8'd3};       // run covers nothing
      send_column();
      col_bytes = '{8'd3, 8'd0, 8'd0};             // skip alone overruns height
      send_column();

      // --- tallest column, largest normal table ---
      drain_columns();
      write_reg(REG_COLUMN_HEIGHT, 8'd255);
      write_reg(REG_NORMAL_MODE, 8'd4);
      col_bytes = '{8'd253, 8'd2, 8'hFF, 8'd243, 8'h00, 8'd0, 8'd2};
      send_column();
      col_bytes = '{8'd0, 8'd1, 8'h5A, 8'd244, 8'd1};  // normal just off the table
      send_column();
      // bad normal, then the body is cut on a colour byte: overrun wins
      col_bytes = '{8'd0, 8'd2, 8'd1, 8'd250, 8'd2};
      send_column();
      col_bytes = '{8'd5, 8'd0, 8'd0};             // ends between runs, short
      send_column();
      col_bytes = '{8'd5, 8'd0, 8'd9};             // reverse copy disagrees
      send_column();

      // --- zero height: everything is trailing ---
      drain_columns();
      write_reg(REG_COLUMN_HEIGHT, 8'd0);
      col_bytes = '{8'd7, 8'd7};
      send_column();

      // --- mode field above four, upper data bits set ---
      drain_columns();
      write_reg(REG_COLUMN_HEIGHT, 8'd3);
      write_reg(REG_NORMAL_MODE, 8'hFF);
      col_bytes = '{8'd0, 8'd1, 8'h3C, 8'd243, 8'd1, 8'd2, 8'd0, 8'd0};
      send_column();
      col_bytes = '{8'd0, 8'd1, 8'd3, 8'd244, 8'd1};
      send_column();

      // --- bytes after the column is full ---
      drain_columns();
      write_reg(REG_NORMAL_MODE, 8'h00);
      col_bytes = '{8'd3, 8'd0, 8'd0, 8'h55};
      send_column();

      // --- smallest table edges, then height lowered mid-column ---
      drain_columns();
      write_reg(REG_COLUMN_HEIGHT, 8'd10);
      write_reg(REG_NORMAL_MODE, 8'h01);
      col_bytes = '{8'd0, 8'd2, 8'd1, 8'd15, 8'd2, 8'd16, 8'd2};
      send_column();
      col_bytes = '{8'd4, 8'd0, 8'd0};             // four covered, column open
      send_column(1'b0);
      drain_columns();
      write_reg(REG_COLUMN_HEIGHT, 8'd3);          // now already past the height
      col_bytes = '{8'd1};
      send_column();

      // --- random phases: new config, then a handful of columns ---
      byte_base   = bytes_taken;
      column_base = columns_seen;
      while (bytes_taken - byte_base < RANDOM_BYTES ||
             columns_seen - column_base < MIN_COLUMNS) begin
         drain_columns();
         case ($urandom_range(0, 9))
            0:       write_reg(REG_COLUMN_HEIGHT, 8'd255);
            1:       write_reg(REG_COLUMN_HEIGHT, 8'd0);
            2:       write_reg(REG_COLUMN_HEIGHT, 8'($urandom_range(13, 254)));
            default: write_reg(REG_COLUMN_HEIGHT, 8'($urandom_range(1, 12)));
         endcase
         write_reg(REG_NORMAL_MODE, {3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))});
         repeat ($urandom_range(2, 6)) begin
            build_column();
            if ($urandom_range(0, 3) == 0) break_column();
            send_column();
         end
      end

      drain_columns();
      if (board.fails == 0 && board.pending() == 0) begin
         $display("tb_voxel_column_run_checker_unit passed");
      end else begin
         $display("tb_voxel_column_run_checker_unit failed");
      end
      $finish;
   end

endmodule
